FILE: design/text_console_cell_writer_top_macros.svh
// ----------------------------------------------------------------------------
// Text console cell writer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_MACROS_SVH

// same-cycle property
`define TCCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies consequence in the next
`define TCCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Payload types, function codes, character constants and control structs.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [2:0] FUNC_PUT    = 3'd0;
  localparam logic [2:0] FUNC_BACK   = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_SCROLL = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [6:0] min_col;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_value;
    logic        dropped;
  } out_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic copy;
    logic fill;
    logic load_out;
    logic value_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       copy_last;
    logic       fill_last;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: design/text_console_cell_writer_top.sv
// ----------------------------------------------------------------------------
// Text console cell writer
// Cursor-driven character cell store with put, backspace, clear, scroll, read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one command (in_data_i);
//   output channel out_valid_o/out_ready_i returns one result per command.
//   One command is in flight at a time; in_ready_o is high only when idle.
//   Put char, newline, backspace and unused codes: the result is loaded into
//   the output register from the execute state, once that register is free.
//   Read cell: one store read port with registered data, so the result is
//   loaded from the read state that follows the execute state.
//   Clear: the fill state writes one blank cell per cycle over the store.
//   Scroll: one cell moved per cycle through the single read and single
//   write port, then the last row blanked.
//   Reset homes the cursor; store contents stay undefined until written and
//   no clearing pass runs.
//   A stalled receiver holds the result in the output register; the next
//   command may be taken, but its result is not committed until the output
//   register frees, so in_ready_o drops meanwhile.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top import tccw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console cell writer controller
// Sequences accept, execute, cell read, scroll copy, blank fill and response.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_top_macros.svh"

module tccw_ctrl import tccw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_READ = 6'b000100,
    ST_COPY = 6'b001000,
    ST_FILL = 6'b010000,
    ST_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.func)
          FUNC_READ: begin
            cmd_o.exec = 1'b1;
            state_d    = ST_READ;
          end
          FUNC_CLEAR: begin
            cmd_o.exec = 1'b1;
            state_d    = ST_FILL;
          end
          FUNC_SCROLL: begin
            cmd_o.exec = 1'b1;
            state_d    = ST_COPY;
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.exec     = 1'b1;
              cmd_o.load_out = 1'b1;
              state_d        = ST_IDLE;
            end
          end
        endcase
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.value_sel = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_last) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TCCW_ASSERT(a_ready_quiet, in_ready_o |-> !(cmd_o.exec || cmd_o.copy || cmd_o.fill), "ready while busy")
  `TCCW_ASSERT_NEXT(a_take_exec, cmd_o.take, state_q == ST_EXEC, "transfer not followed by execute")
  `TCCW_ASSERT(a_load_free, cmd_o.load_out |-> sts_i.out_free, "result loaded into full output")

endmodule

FILE: design/tccw_datapath.sv
// ----------------------------------------------------------------------------
// Text console cell writer datapath
// Cursor registers, cell store, sweep counter and output register.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_top_macros.svh"

module tccw_datapath import tccw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_t      in_data_i,
  input  ctl_cmd_t cmd_i,
  output dp_sts_t  sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_t     out_data_o
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int CMP_W      = (COL_W > 7) ? COL_W : 7;

  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] MOVE_A      = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ADDR_W-1:0] FILL_LAST_A = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ROW_W-1:0]  ROW_END     = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);

  in_t               in_q;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              rd_ok_q, rd_ok_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  cell_t             rdata_q;
  cell_t             mem [CELL_COUNT];

  logic              we, re, drop, row_on, bs_go, rd_in;
  logic [ADDR_W-1:0] wa, ra, cur_base, put_addr, bs_addr, rd_addr;
  logic [COL_W-1:0]  bs_col;
  cell_t             wd, blank;

  assign blank    = {in_q.color, BLANK_CODE};
  assign row_on   = cur_row_q != ROW_END;
  assign cur_base = ADDR_W'(cur_row_q) * COLS_A;
  assign put_addr = cur_base + ADDR_W'(cur_col_q);
  assign bs_col   = cur_col_q - COL_W'(1);
  assign bs_addr  = cur_base + ADDR_W'(bs_col);
  assign bs_go    = CMP_W'(cur_col_q) > CMP_W'(in_q.min_col);
  assign rd_in    = (32'(in_q.read_row) < 32'(ROWS)) && (32'(in_q.read_col) < 32'(COLUMNS));
  assign rd_addr  = ADDR_W'(in_q.read_row) * COLS_A + ADDR_W'(in_q.read_col);

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    rd_ok_d   = rd_ok_q;
    drop      = 1'b0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    re        = 1'b0;
    ra        = '0;
    if (cmd_i.exec) begin
      case (in_q.func)
        FUNC_PUT: begin
          if (in_q.char_code == NEWLINE_CODE) begin
            cur_col_d = '0;
            if (row_on) begin
              cur_row_d = cur_row_q + ROW_W'(1);
            end
          end else if (!row_on) begin
            drop = 1'b1;
          end else begin
            we = 1'b1;
            wa = put_addr;
            wd = {in_q.color, in_q.char_code};
            if (cur_col_q == COL_LAST) begin
              cur_col_d = '0;
              cur_row_d = cur_row_q + ROW_W'(1);
            end else begin
              cur_col_d = cur_col_q + COL_W'(1);
            end
          end
        end
        FUNC_BACK: begin
          if (bs_go) begin
            cur_col_d = bs_col;
            if (row_on) begin
              we = 1'b1;
              wa = bs_addr;
              wd = blank;
            end else begin
              drop = 1'b1;
            end
          end
        end
        FUNC_CLEAR: begin
          cur_row_d = '0;
          cur_col_d = '0;
          cnt_d     = '0;
        end
        FUNC_SCROLL: begin
          cur_row_d = ROW_LAST;
          cur_col_d = '0;
          cnt_d     = '0;
          pend_d    = 1'b0;
        end
        FUNC_READ: begin
          rd_ok_d = rd_in;
          re      = rd_in;
          ra      = rd_addr;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.copy) begin
      if (pend_q) begin
        we = 1'b1;
        wa = cnt_q - ADDR_W'(1);
        wd = rdata_q;
      end
      if (cnt_q != MOVE_A) begin
        re     = 1'b1;
        ra     = cnt_q + COLS_A;
        cnt_d  = cnt_q + ADDR_W'(1);
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (cmd_i.fill) begin
      we    = 1'b1;
      wa    = cnt_q;
      wd    = blank;
      cnt_d = cnt_q + ADDR_W'(1);
    end
  end

  always_comb begin
    out_d.cursor_row = 5'(cur_row_d);
    out_d.cursor_col = 7'(cur_col_d);
    out_d.cell_value = (cmd_i.value_sel && rd_ok_q) ? rdata_q : '0;
    out_d.dropped    = drop;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      in_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  assign sts_o.func      = in_q.func;
  assign sts_o.copy_last = cnt_q == MOVE_A;
  assign sts_o.fill_last = cnt_q == FILL_LAST_A;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCCW_ASSERT(a_row_range, 32'(cur_row_q) <= 32'(ROWS), "cursor row beyond screen end")
  `TCCW_ASSERT(a_col_range, 32'(cur_col_q) < 32'(COLUMNS), "cursor column beyond line")
  `TCCW_ASSERT(a_write_range, we |-> (32'(wa) < 32'(CELL_COUNT)), "cell write out of store")
  `TCCW_ASSERT_NEXT(a_load_valid, cmd_i.load_out, out_valid_q, "loaded result not presented")

endmodule

FILE: test/text_console_cell_writer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console cell writer testbench
// Drives put, newline, backspace, clear, scroll, read and unused commands,
// predicts cursor, cell contents and drop flag in a shadow console, and
// checks every result transfer in order under random idling and back-pressure.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top_tb;
  import tccw_pkg::*;

  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;

  localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 50;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  logic [15:0] shadow_cells [CELLS];
  bit          shadow_written [CELLS];
  int          shadow_row;
  int          shadow_col;

  out_t pending_results [$];
  int   mismatch_count;
  int   cycle_count;
  int   sent_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   rx_hold_cycles;

  text_console_cell_writer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [15:0] blank_of(input logic [7:0] color);
    return {color, BLANK_CODE};
  endfunction

  task automatic advance_row();
    shadow_col = 0;
    if (shadow_row < ROWS) shadow_row++;
  endtask

  task automatic predict_console(input in_t cmd, output out_t res);
    int idx;
    res = '0;
    case (cmd.func)
      FUNC_PUT: begin
        if (cmd.char_code == NEWLINE_CODE) begin
          advance_row();
        end else if (shadow_row >= ROWS) begin
          res.dropped = 1'b1;
        end else begin
          idx = shadow_row * COLS + shadow_col;
          shadow_cells[idx]   = {cmd.color, cmd.char_code};
          shadow_written[idx] = 1'b1;
          shadow_col++;
          if (shadow_col >= COLS) advance_row();
        end
      end
      FUNC_BACK: begin
        if (shadow_col > cmd.min_col) begin
          shadow_col--;
          if (shadow_row < ROWS) begin
            idx = shadow_row * COLS + shadow_col;
            shadow_cells[idx]   = blank_of(cmd.color);
            shadow_written[idx] = 1'b1;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      FUNC_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++) begin
          shadow_cells[idx]   = blank_of(cmd.color);
          shadow_written[idx] = 1'b1;
        end
        shadow_row = 0;
        shadow_col = 0;
      end
      FUNC_SCROLL: begin
        for (idx = 0; idx < CELLS - COLS; idx++) begin
          shadow_cells[idx]   = shadow_cells[idx + COLS];
          shadow_written[idx] = shadow_written[idx + COLS];
        end
        for (idx = CELLS - COLS; idx < CELLS; idx++) begin
          shadow_cells[idx]   = blank_of(cmd.color);
          shadow_written[idx] = 1'b1;
        end
        shadow_row = ROWS - 1;
        shadow_col = 0;
      end
      FUNC_READ: begin
        if (cmd.read_row < ROWS && cmd.read_col < COLS)
          res.cell_value = shadow_cells[cmd.read_row * COLS + cmd.read_col];
      end
      default: begin
      end
    endcase
    res.cursor_row = shadow_row[4:0];
    res.cursor_col = shadow_col[6:0];
  endtask

  function automatic in_t make_cmd(input logic [2:0] func, input logic [7:0] char_code,
                                   input logic [7:0] color, input logic [6:0] min_col,
                                   input logic [4:0] read_row, input logic [6:0] read_col);
    in_t cmd;
    cmd.func      = func;
    cmd.char_code = char_code;
    cmd.color     = color;
    cmd.min_col   = min_col;
    cmd.read_row  = read_row;
    cmd.read_col  = read_col;
    return cmd;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_cmd(input in_t cmd);
    out_t res;
    if (cmd.func == FUNC_READ && cmd.read_row < ROWS && cmd.read_col < COLS &&
        !shadow_written[cmd.read_row * COLS + cmd.read_col])
      cmd.read_row = 5'(ROWS);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_console(cmd, res);
    pending_results.push_back(res);
    sent_count++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_data_o.cursor_row);
          mismatch_count++;
        end
        if (out_data_o.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, out_data_o.cursor_col);
          mismatch_count++;
        end
        if (out_data_o.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, out_data_o.cell_value);
          mismatch_count++;
        end
        if (out_data_o.dropped !== want.dropped) begin
          $error("dropped: expected %0d, got %0d", want.dropped, out_data_o.dropped);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] rand_col_field();
    return 7'($urandom_range(127));
  endfunction

  function automatic logic [4:0] rand_row_field();
    return 5'($urandom_range(31));
  endfunction

  task automatic send_put(input logic [7:0] char_code, input logic [7:0] color);
    send_cmd(make_cmd(FUNC_PUT, char_code, color, rand_col_field(), rand_row_field(),
                      rand_col_field()));
  endtask

  task automatic send_back(input logic [6:0] min_col, input logic [7:0] color);
    send_cmd(make_cmd(FUNC_BACK, rand_byte(), color, min_col, rand_row_field(),
                      rand_col_field()));
  endtask

  task automatic send_read(input logic [4:0] read_row, input logic [6:0] read_col);
    send_cmd(make_cmd(FUNC_READ, rand_byte(), rand_byte(), rand_col_field(), read_row,
                      read_col));
  endtask

  task automatic send_walk(input logic [2:0] func, input logic [7:0] color);
    send_cmd(make_cmd(func, rand_byte(), color, rand_col_field(), rand_row_field(),
                      rand_col_field()));
  endtask

  task automatic test_put_and_read();
    send_put(8'h41, 8'h00);
    send_put(8'hFF, 8'hFF);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
  endtask

  task automatic test_clear();
    send_walk(FUNC_CLEAR, 8'h1E);
    send_read(5'(ROWS - 1), 7'(COLS - 1));
  endtask

  task automatic test_backspace();
    send_put(8'h00, 8'h2A);
    send_put(8'h79, 8'h2A);
    send_back(7'd1, 8'hC3);
    send_back(7'd1, 8'hC3);
    send_back(7'd127, 8'hC3);
    send_back(7'd0, 8'h5A);
    send_read(5'd0, 7'd1);
  endtask

  task automatic test_read_range();
    send_read(5'(ROWS), 7'd0);
    send_read(5'd31, 7'd127);
    send_read(5'd0, 7'(COLS));
  endtask

  task automatic test_unused_funcs();
    int code;
    for (code = FUNC_UNUSED_FIRST; code <= FUNC_UNUSED_LAST; code++)
      send_walk(3'(code), rand_byte());
  endtask

  task automatic test_scroll();
    send_put(8'h7A, 8'h4E);
    send_put(NEWLINE_CODE, 8'h00);
    send_walk(FUNC_SCROLL, 8'h70);
    send_read(5'(ROWS - 1), 7'd0);
  endtask

  task automatic test_past_screen();
    send_put(NEWLINE_CODE, 8'h00);
    send_put(NEWLINE_CODE, 8'h00);
    send_put(8'h71, 8'h0F);
    send_back(7'd0, 8'h0F);
  endtask

  task automatic test_backpressure();
    int n;
    rx_hold_cycles = 300;
    for (n = 0; n < 12; n++) send_put(rand_byte(), rand_byte());
  endtask

  task automatic random_text_run(input int count);
    int n;
    logic [7:0] ch;
    for (n = 0; n < count; n++) begin
      ch = ($urandom_range(9) == 0) ? NEWLINE_CODE : rand_byte();
      send_put(ch, rand_byte());
    end
  endtask

  task automatic random_scenario();
    int pick;
    int n;
    logic [6:0] floor_col;
    pick = $urandom_range(99);
    if (shadow_row >= ROWS && $urandom_range(1) == 0)
      pick = 95;
    if (pick < 45) begin
      random_text_run($urandom_range(1, 40));
    end else if (pick < 60) begin
      for (n = $urandom_range(1, 6); n > 0; n--) begin
        case ($urandom_range(2))
          0: floor_col = 7'd0;
          1: floor_col = rand_col_field();
          default: floor_col = (shadow_col > 1) ? 7'(shadow_col - 2) : 7'd0;
        endcase
        send_back(floor_col, rand_byte());
      end
    end else if (pick < 72) begin
      for (n = $urandom_range(1, 5); n > 0; n--) begin
        if ($urandom_range(99) < 85)
          send_read(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
        else
          send_read(rand_row_field(), rand_col_field());
      end
    end else if (pick < 78) begin
      send_walk(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)), rand_byte());
      send_put(rand_byte(), rand_byte());
    end else if (pick < 85) begin
      while (shadow_row < ROWS) send_put(NEWLINE_CODE, rand_byte());
      for (n = $urandom_range(1, 4); n > 0; n--) begin
        if ($urandom_range(1) == 0) send_put(rand_byte(), rand_byte());
        else send_back(rand_col_field(), rand_byte());
      end
      if ($urandom_range(1) == 0) send_walk(FUNC_SCROLL, rand_byte());
    end else if (pick < 93) begin
      random_text_run(COLS - shadow_col + $urandom_range(0, 3));
    end else begin
      send_walk(($urandom_range(1) == 0) ? FUNC_CLEAR : FUNC_SCROLL, rand_byte());
    end
  endtask

  task automatic test_random_traffic();
    int start_count;
    start_count = sent_count;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      if (sent_count - start_count < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct = 77;
      end else if (sent_count - start_count < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 77;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_scenario();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    shadow_row     = 0;
    shadow_col     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    sent_count     = 0;
    tx_idle_pct    = 22;
    rx_idle_pct    = 77;
    rx_hold_cycles = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_put_and_read();
    test_clear();
    test_backspace();
    test_read_range();
    test_unused_funcs();
    test_scroll();
    test_past_screen();
    test_backpressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
